/* rtl/ttpt_pkg.sv */
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared types and constants for the tick/tock phase trim timer.
// ----------------------------------------------------------------------------
package ttpt_pkg;

  // Input item codes; code 7 is unused and ignored
  typedef enum logic [2:0] {
    KIND_ELAPSED     = 3'd0,
    KIND_START       = 3'd1,
    KIND_STOP        = 3'd2,
    KIND_TRIM_UP     = 3'd3,
    KIND_TRIM_DOWN   = 3'd4,
    KIND_TRIM_CLEAR  = 3'd5,
    KIND_PHASE_SHIFT = 3'd6
  } ttpt_kind_t;

  typedef enum logic {
    EV_TICK = 1'b0,
    EV_TOCK = 1'b1
  } ttpt_event_t;

  typedef struct packed {
    logic        event_kind;
    logic [30:0] next_period;
  } ttpt_result_t;

  localparam logic [15:0] INTERVAL_RESET = 16'd4000;
  localparam logic [30:0] PERIOD_MAX     = 31'h7FFF_FFFF;
  localparam logic [31:0] TRIM_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] TRIM_MIN       = 32'h8000_0000;

endpackage

/* rtl/ttpt_out_buf.sv */
// ----------------------------------------------------------------------------
// ttpt_out_buf
// Result register with a skid stage, so the input side never waits on a
// stalled output for more than the one item held in the skid.
// ----------------------------------------------------------------------------
module ttpt_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ttpt_pkg::ttpt_result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ttpt_pkg::ttpt_result_t out_data
);
  import ttpt_pkg::*;

  ttpt_result_t skid_data;
  logic         skid_valid;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/tick_tock_phase_trim_timer_core.sv */
// Results go into the output register; a one-entry skid stage absorbs an
// output stall. Throughput: one item per cycle while the skid stage is
// empty (in_ready high).
// Reset (rst, synchronous): timer stopped, tick phase, trim and pending shift
// cleared, interval 4000 us, output and skid stages empty.
// ----------------------------------------------------------------------------
// tick_tock_phase_trim_timer_core
// Half-period timer firing alternating tick and tock events, with frequency
// trim and a one-shot phase shift applied on tock halves.
// ----------------------------------------------------------------------------
module tick_tock_phase_trim_timer_core #(
  parameter int TICKS_PER_US = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic signed [31:0] shift_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_kind,
  output logic [30:0] next_period
);
  import ttpt_pkg::*;

  localparam int TW     = $clog2(TICKS_PER_US + 1);
  localparam int FULL_W = 16 + TW;

  logic [15:0]        interval_us;
  logic               running;
  logic               tick_phase;
  logic signed [31:0] pending_shift;
  logic signed [31:0] freq_trim;
  logic [30:0]        remaining;

  logic               running_next;
  logic               tick_phase_next;
  logic signed [31:0] pending_shift_next;
  logic signed [31:0] freq_trim_next;
  logic [30:0]        remaining_next;

  logic [FULL_W-1:0]  full;
  logic [FULL_W-1:0]  half;
  logic [FULL_W-1:0]  lim;
  logic signed [33:0] reload;
  logic [30:0]        period;
  logic [30:0]        start_period;
  logic signed [32:0] lim_s;
  logic signed [32:0] shift_c;
  logic signed [32:0] shift_scaled;
  logic               accept;
  logic               push;
  ttpt_result_t       push_data;
  ttpt_result_t       out_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign full  = FULL_W'(interval_us) * FULL_W'(TICKS_PER_US);
  assign half  = full >> 1;
  assign lim   = full >> 2;
  assign lim_s = $signed(33'(lim));

  // Tock halves carry the pending phase shift on top of the trim
  assign reload = $signed(34'(half))
                + (tick_phase ? 34'sd0 : 34'(pending_shift))
                + 34'(freq_trim);

  always_comb begin
    if (reload < 34'sd1) begin
      period = 31'd1;
    end else if (reload > $signed({3'b000, PERIOD_MAX})) begin
      period = PERIOD_MAX;
    end else begin
      period = reload[30:0];
    end
  end

  assign start_period = (half == '0) ? 31'd1 : 31'(half);

  always_comb begin
    shift_c = 33'(shift_value);
    if (shift_c > lim_s) begin
      shift_c = lim_s;
    end
    if (shift_c < -lim_s) begin
      shift_c = -lim_s;
    end
  end

  // Bounded by interval*ticks*ticks/4, so never near the 32-bit limits
  assign shift_scaled = shift_c * $signed(33'(TICKS_PER_US));

  always_comb begin
    running_next       = running;
    tick_phase_next    = tick_phase;
    pending_shift_next = pending_shift;
    freq_trim_next     = freq_trim;
    remaining_next     = remaining;
    push               = 1'b0;
    push_data.event_kind  = tick_phase ? EV_TICK : EV_TOCK;
    push_data.next_period = period;
    if (accept) begin
      case (kind)
        KIND_ELAPSED: begin
          if (running) begin
            if (remaining > 31'd1) begin
              remaining_next = remaining - 31'd1;
            end else begin
              push            = 1'b1;
              remaining_next  = period;
              tick_phase_next = !tick_phase;
              if (!tick_phase) begin
                pending_shift_next = '0;
              end
            end
          end
        end
        KIND_START: begin
          if (!running) begin
            remaining_next  = start_period;
            tick_phase_next = 1'b1;
            running_next    = 1'b1;
          end
        end
        KIND_STOP: begin
          running_next = 1'b0;
        end
        KIND_TRIM_UP: begin
          if (freq_trim != $signed(TRIM_MAX)) begin
            freq_trim_next = freq_trim + 32'sd1;
          end
        end
        KIND_TRIM_DOWN: begin
          if (freq_trim != $signed(TRIM_MIN)) begin
            freq_trim_next = freq_trim - 32'sd1;
          end
        end
        KIND_TRIM_CLEAR: begin
          freq_trim_next = '0;
        end
        KIND_PHASE_SHIFT: begin
          pending_shift_next = shift_scaled[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_us   <= INTERVAL_RESET;
      running       <= 1'b0;
      tick_phase    <= 1'b1;
      pending_shift <= '0;
      freq_trim     <= '0;
      remaining     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_us <= cfg_data;
      end
      running       <= running_next;
      tick_phase    <= tick_phase_next;
      pending_shift <= pending_shift_next;
      freq_trim     <= freq_trim_next;
      remaining     <= remaining_next;
    end
  end

  ttpt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign event_kind  = out_data.event_kind;
  assign next_period = out_data.next_period;

endmodule

/* dv/tick_tock_phase_trim_timer_core_tb.sv */
// ----------------------------------------------------------------------------
// tick_tock_phase_trim_timer_core_tb
// Drives timer items and interval writes with bursty input and a stalling
// output side; a scoreboard tracks the countdown, trim and pending shift,
// works out each tick/tock event and checks the block's results in order.
// ----------------------------------------------------------------------------
module tick_tock_phase_trim_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttpt_pkg::*;

  localparam int          TICKS_PER_US = 5;
  localparam logic [2:0]  KIND_UNUSED  = 3'd7;
  localparam logic [31:0] SHIFT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SHIFT_NEG_MAX = 32'h8000_0000;

  class timer_scoreboard;
    bit [15:0]    interval_us;
    bit           running;
    bit           tick_phase;
    int           pending_shift;
    int           freq_trim;
    bit [31:0]    remaining;
    ttpt_result_t due_events[$];
    int           errors;

    function new();
      interval_us   = INTERVAL_RESET;
      running       = 1'b0;
      tick_phase    = 1'b1;
      pending_shift = 0;
      freq_trim     = 0;
      remaining     = '0;
      errors        = 0;
    endfunction

    function void set_interval(bit [15:0] v);
      interval_us = v;
    endfunction

    function int outstanding();
      return due_events.size();
    endfunction

    function bit [30:0] clamp_period(longint v);
      if (v < 1) return 31'd1;
      if (v > longint'(PERIOD_MAX)) return PERIOD_MAX;
      return v[30:0];
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    // Works out the timer's response to one accepted transaction
    function void note_item(logic [2:0] k, logic signed [31:0] s);
      longint       half;
      longint       reload;
      longint       lim;
      longint       sh;
      ttpt_result_t ev;
      half = (longint'(interval_us) * TICKS_PER_US) >>> 1;
      case (k)
        KIND_ELAPSED: begin
          if (running) begin
            if (remaining > 1) begin
              remaining--;
            end else begin
              if (tick_phase) begin
                reload        = half + longint'(freq_trim);
                ev.event_kind = EV_TICK;
              end else begin
                reload        = half + longint'(pending_shift) + longint'(freq_trim);
                pending_shift = 0;
                ev.event_kind = EV_TOCK;
              end
              ev.next_period = clamp_period(reload);
              remaining      = {1'b0, ev.next_period};
              tick_phase     = !tick_phase;
              due_events.push_back(ev);
            end
          end
        end
        KIND_START: begin
          if (!running) begin
            remaining  = {1'b0, clamp_period(half)};
            tick_phase = 1'b1;
            running    = 1'b1;
          end
        end
        KIND_STOP:       running = 1'b0;
        KIND_TRIM_UP:    freq_trim = sat32(longint'(freq_trim) + 1);
        KIND_TRIM_DOWN:  freq_trim = sat32(longint'(freq_trim) - 1);
        KIND_TRIM_CLEAR: freq_trim = 0;
        KIND_PHASE_SHIFT: begin
          lim = (longint'(interval_us) * TICKS_PER_US) >>> 2;
          sh  = longint'(s);
          if (sh > lim) sh = lim;
          if (sh < -lim) sh = -lim;
          pending_shift = sat32(sh * TICKS_PER_US);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_event(logic ev_kind, logic [30:0] period);
      ttpt_result_t want;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d period %0d", ev_kind, period));
        return;
      end
      want = due_events.pop_front();
      if (ev_kind !== want.event_kind)
        report_mismatch($sformatf("event_kind got %0d, expected %0d", ev_kind,
                                  want.event_kind));
      if (period !== want.next_period)
        report_mismatch($sformatf("next_period got %0d, expected %0d", period,
                                  want.next_period));
    endtask
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [2:0]         kind        = '0;
  logic signed [31:0] shift_value = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               event_kind;
  logic [30:0]        next_period;

  timer_scoreboard sb;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  tick_tock_phase_trim_timer_core #(
    .TICKS_PER_US (TICKS_PER_US)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .shift_value (shift_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .next_period (next_period)
  );

  always #5 clk = ~clk;

  // Result side: check accepted transactions, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_event(event_kind, next_period);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task send_item(logic [2:0] k, logic [31:0] s);
    in_valid    <= 1'b1;
    kind        <= k;
    shift_value <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, s);
  endtask

  // Bursts of random length with random gaps; some bursts run back to back
  task sender_pause();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task write_interval(logic [15:0] v);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_interval(v);
    cfg_valid <= 1'b0;
  endtask

  function logic [31:0] pick_shift();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SHIFT_POS_MAX;
          1:       return SHIFT_NEG_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task run_random(int n_items);
    int          done;
    int          r;
    logic [2:0]  k;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55)      k = KIND_ELAPSED;
      else if (r < 63) k = KIND_START;
      else if (r < 67) k = KIND_STOP;
      else if (r < 74) k = KIND_TRIM_UP;
      else if (r < 81) k = KIND_TRIM_DOWN;
      else if (r < 84) k = KIND_TRIM_CLEAR;
      else if (r < 97) k = KIND_PHASE_SHIFT;
      else             k = KIND_UNUSED;
      // ignored transactions don't count towards the phase length
      if (k != KIND_UNUSED && !(k == KIND_ELAPSED && !sb.running)) done++;
      sender_pause();
      send_item(k, (k == KIND_PHASE_SHIFT) ? pick_shift() : $urandom);
    end
  endtask

  initial begin
    logic [2:0]  dir_kind[25];
    logic [31:0] dir_shift[25];
    logic [15:0] phase_iv[9];
    int          phase_len;
    sb = new();
    dir_kind = '{KIND_ELAPSED, KIND_UNUSED, KIND_STOP, KIND_TRIM_UP, KIND_TRIM_CLEAR,
                 KIND_START, KIND_START, KIND_PHASE_SHIFT, KIND_ELAPSED, KIND_ELAPSED,
                 KIND_TRIM_DOWN, KIND_ELAPSED, KIND_ELAPSED, KIND_PHASE_SHIFT, KIND_STOP,
                 KIND_ELAPSED, KIND_START, KIND_ELAPSED, KIND_ELAPSED, KIND_ELAPSED,
                 KIND_ELAPSED, KIND_TRIM_CLEAR, KIND_PHASE_SHIFT, KIND_ELAPSED, KIND_STOP};
    foreach (dir_shift[i]) dir_shift[i] = $urandom;
    dir_shift[7]  = SHIFT_POS_MAX;
    dir_shift[13] = SHIFT_NEG_MAX;
    dir_shift[22] = '0;
    phase_iv = '{16'd0, 16'd3, 16'd65535, 16'd2, INTERVAL_RESET, 16'd6,
                 16'($urandom_range(1, 12)), 16'd7, 16'd1};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: short interval so both phases, the lower period clamp and the
    // shift limits show up within a handful of transactions
    write_interval(16'd1);
    foreach (dir_kind[i]) begin
      sender_pause();
      send_item(dir_kind[i], dir_shift[i]);
    end

    // Interval changes land mid-countdown; the new value applies at next reload
    foreach (phase_iv[p]) begin
      write_interval(phase_iv[p]);
      phase_len = (phase_iv[p] > 16'd100) ? 15 : 40;
      run_random(phase_len);
    end

    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/ttpt_pkg.sv
rtl/ttpt_out_buf.sv
rtl/tick_tock_phase_trim_timer_core.sv
dv/tick_tock_phase_trim_timer_core_tb.sv
